// File: src/fdmx_pkg.sv
// Shared types, codes and constants for the dual protocol frame demultiplexer.
// The CRC-16-CCITT byte update lives here as a function. No dependencies.
package fdmx_pkg;

	localparam int unsigned SHORT_MAX_LEN = 64;

	localparam logic [7:0]  SHORT_MIN_LEN      = 8'd5;
	localparam logic [7:0]  LONG_SYNC          = 8'h55;
	localparam logic [15:0] LONG_MIN_LEN_FIELD = 16'd5;
	localparam logic [16:0] LONG_OVERHEAD      = 17'd6;
	localparam logic [15:0] CRC_SEED           = 16'hffff;
	localparam logic [23:0] IDLE_MAX           = 24'hffffff;

	localparam logic [23:0] TIMEOUT_RESET = 24'd100000;
	localparam logic [16:0] MAX_LEN_RESET = 17'd4096;
	localparam logic [16:0] STAGING_RESET = 17'd1024;
	localparam logic [7:0]  STREAM_RESET  = 8'd0;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STAGING  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM   = 3'd3;

	typedef enum logic [1:0] {
		MODE_WAITING = 2'd0,
		MODE_SHORT   = 2'd1,
		MODE_LONG    = 2'd2,
		MODE_STREAM  = 2'd3
	} mode_t;

	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_SHORT_DONE   = 3'd1;
	localparam logic [2:0] EV_LONG_GOOD    = 3'd2;
	localparam logic [2:0] EV_ERROR        = 3'd3;
	localparam logic [2:0] EV_STREAM_BEGIN = 3'd4;
	localparam logic [2:0] EV_STREAM_BYTE  = 3'd5;
	localparam logic [2:0] EV_STREAM_DONE  = 3'd6;

	localparam logic [1:0] DEST_DROP   = 2'd0;
	localparam logic [1:0] DEST_SHORT  = 2'd1;
	localparam logic [1:0] DEST_LONG   = 2'd2;
	localparam logic [1:0] DEST_STREAM = 2'd3;

	localparam logic CMD_BYTE = 1'b0;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  byte_out;
		logic [1:0]  destination;
		logic [15:0] byte_index;
		logic [7:0]  channel_out;
		logic [15:0] frame_len;
		logic        crc_mismatch;
		logic        timed_out;
	} result_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  d;
		logic [15:0] dw;
		d  = b ^ crc[7:0];
		d  = d ^ {d[3:0], 4'b0000};
		dw = {8'h00, d};
		return {d, crc[15:8]} ^ (dw >> 4) ^ (dw << 3);
	endfunction

endpackage

// File: src/fdmx_front.sv
// Front part of the demultiplexer: configuration registers, frame state and
// the per-word classification that builds one result. Uses fdmx_pkg.
module fdmx_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fdmx_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fdmx_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              accept,
	input  logic                              cmd,
	input  logic [7:0]                        data,
	output fdmx_pkg::result_t                 result
);

	logic [23:0] timeout_q;
	logic [16:0] max_len_q;
	logic [16:0] staging_q;
	logic [7:0]  stream_q;

	fdmx_pkg::mode_t mode_q, mode_d;
	logic [16:0] position_q, position_d;
	logic [15:0] remaining_q, remaining_d;
	logic [16:0] total_q, total_d;
	logic [7:0]  length_low_q, length_low_d;
	logic [7:0]  channel_q, channel_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic        crc_low_seen_q, crc_low_seen_d;
	logic [23:0] idle_q, idle_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= fdmx_pkg::TIMEOUT_RESET;
			max_len_q <= fdmx_pkg::MAX_LEN_RESET;
			staging_q <= fdmx_pkg::STAGING_RESET;
			stream_q  <= fdmx_pkg::STREAM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fdmx_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				fdmx_pkg::REG_MAX_LEN: max_len_q <= cfg_data[16:0];
				fdmx_pkg::REG_STAGING: staging_q <= cfg_data[16:0];
				fdmx_pkg::REG_STREAM:  stream_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= fdmx_pkg::MODE_WAITING;
			position_q     <= '0;
			remaining_q    <= '0;
			total_q        <= '0;
			length_low_q   <= '0;
			channel_q      <= '0;
			crc_q          <= fdmx_pkg::CRC_SEED;
			crc_low_q      <= '0;
			crc_low_seen_q <= 1'b0;
			idle_q         <= '0;
		end else if (accept) begin
			mode_q         <= mode_d;
			position_q     <= position_d;
			remaining_q    <= remaining_d;
			total_q        <= total_d;
			length_low_q   <= length_low_d;
			channel_q      <= channel_d;
			crc_q          <= crc_d;
			crc_low_q      <= crc_low_d;
			crc_low_seen_q <= crc_low_seen_d;
			idle_q         <= idle_d;
		end
	end

	logic [15:0] crc_next;
	logic [15:0] field;
	logic [16:0] field_total;
	logic [17:0] pos_plus2;
	logic [16:0] payload_len;
	logic        crc_match;

	assign crc_next    = fdmx_pkg::crc_step(crc_q, data);
	assign field       = {data, length_low_q};
	assign field_total = {1'b0, field} + 17'd1;
	assign pos_plus2   = {1'b0, position_q} + 18'd2;
	assign payload_len = total_q - fdmx_pkg::LONG_OVERHEAD;
	assign crc_match   = ({data, crc_low_q} == crc_q);

	always_comb begin
		mode_d         = mode_q;
		position_d     = position_q;
		remaining_d    = remaining_q;
		total_d        = total_q;
		length_low_d   = length_low_q;
		channel_d      = channel_q;
		crc_d          = crc_q;
		crc_low_d      = crc_low_q;
		crc_low_seen_d = crc_low_seen_q;
		idle_d         = idle_q;
		result         = '0;

		if (cmd != fdmx_pkg::CMD_BYTE) begin
			if (idle_q < fdmx_pkg::IDLE_MAX) begin
				idle_d = idle_q + 24'd1;
			end
		end else begin
			result.byte_out   = data;
			idle_d            = '0;
			result.byte_index = position_q[15:0];
			// A stale partial frame is dropped and the word starts afresh.
			if (mode_q != fdmx_pkg::MODE_WAITING && idle_q > timeout_q) begin
				mode_d           = fdmx_pkg::MODE_WAITING;
				result.timed_out = 1'b1;
				result.byte_index = '0;
				position_d       = '0;
				remaining_d      = '0;
				total_d          = '0;
			end

			case (mode_d)
				fdmx_pkg::MODE_WAITING: begin
					result.byte_index = '0;
					if (data >= fdmx_pkg::SHORT_MIN_LEN &&
					    data <= 8'(fdmx_pkg::SHORT_MAX_LEN)) begin
						mode_d             = fdmx_pkg::MODE_SHORT;
						position_d         = 17'd1;
						remaining_d        = {8'h00, data} - 16'd1;
						result.destination = fdmx_pkg::DEST_SHORT;
					end else if (data == fdmx_pkg::LONG_SYNC) begin
						mode_d             = fdmx_pkg::MODE_LONG;
						position_d         = 17'd1;
						total_d            = '0;
						crc_d              = fdmx_pkg::CRC_SEED;
						crc_low_seen_d     = 1'b0;
						result.destination = fdmx_pkg::DEST_LONG;
					end
				end
				fdmx_pkg::MODE_SHORT: begin
					result.destination = fdmx_pkg::DEST_SHORT;
					position_d         = position_q + 17'd1;
					remaining_d        = remaining_q - 16'd1;
					if (remaining_d == '0) begin
						result.event_res = fdmx_pkg::EV_SHORT_DONE;
						result.frame_len = position_d[15:0];
						mode_d           = fdmx_pkg::MODE_WAITING;
						position_d       = '0;
						remaining_d      = '0;
						total_d          = '0;
					end
				end
				fdmx_pkg::MODE_LONG: begin
					if (position_q >= staging_q) begin
						result.event_res = fdmx_pkg::EV_ERROR;
						mode_d           = fdmx_pkg::MODE_WAITING;
						position_d       = '0;
						remaining_d      = '0;
						total_d          = '0;
					end else if (position_q == 17'd1) begin
						length_low_d       = data;
						crc_d              = crc_next;
						position_d         = 17'd2;
						result.destination = fdmx_pkg::DEST_LONG;
					end else if (position_q == 17'd2) begin
						if (field < fdmx_pkg::LONG_MIN_LEN_FIELD || field_total > max_len_q) begin
							result.event_res = fdmx_pkg::EV_ERROR;
							mode_d           = fdmx_pkg::MODE_WAITING;
							position_d       = '0;
							remaining_d      = '0;
							total_d          = '0;
						end else begin
							total_d            = field_total;
							crc_d              = crc_next;
							position_d         = 17'd3;
							result.destination = fdmx_pkg::DEST_LONG;
						end
					end else if (position_q == 17'd3) begin
						channel_d          = data;
						result.channel_out = data;
						crc_d              = crc_next;
						if (data == stream_q) begin
							remaining_d        = payload_len[15:0];
							crc_low_seen_d     = 1'b0;
							mode_d             = fdmx_pkg::MODE_STREAM;
							position_d         = 17'd4;
							result.event_res   = fdmx_pkg::EV_STREAM_BEGIN;
							result.destination = fdmx_pkg::DEST_LONG;
						end else if (total_q > staging_q) begin
							result.event_res = fdmx_pkg::EV_ERROR;
							mode_d           = fdmx_pkg::MODE_WAITING;
							position_d       = '0;
							remaining_d      = '0;
							total_d          = '0;
						end else begin
							position_d         = 17'd4;
							result.destination = fdmx_pkg::DEST_LONG;
						end
					end else begin
						result.channel_out = channel_q;
						result.destination = fdmx_pkg::DEST_LONG;
						if (pos_plus2 < {1'b0, total_q}) begin
							crc_d      = crc_next;
							position_d = position_q + 17'd1;
						end else if (pos_plus2 == {1'b0, total_q}) begin
							crc_low_d  = data;
							position_d = position_q + 17'd1;
						end else begin
							if (crc_match) begin
								result.event_res = fdmx_pkg::EV_LONG_GOOD;
								result.frame_len = payload_len[15:0];
							end else begin
								result.event_res    = fdmx_pkg::EV_ERROR;
								result.crc_mismatch = 1'b1;
							end
							mode_d      = fdmx_pkg::MODE_WAITING;
							position_d  = '0;
							remaining_d = '0;
							total_d     = '0;
						end
					end
				end
				default: begin
					result.channel_out = channel_q;
					if (remaining_q != '0) begin
						crc_d              = crc_next;
						remaining_d        = remaining_q - 16'd1;
						position_d         = position_q + 17'd1;
						result.event_res   = fdmx_pkg::EV_STREAM_BYTE;
						result.destination = fdmx_pkg::DEST_STREAM;
					end else if (!crc_low_seen_q) begin
						crc_low_d      = data;
						crc_low_seen_d = 1'b1;
						position_d     = position_q + 17'd1;
					end else begin
						if (crc_match) begin
							result.event_res = fdmx_pkg::EV_STREAM_DONE;
							result.frame_len = payload_len[15:0];
						end else begin
							result.event_res    = fdmx_pkg::EV_ERROR;
							result.crc_mismatch = 1'b1;
						end
						mode_d      = fdmx_pkg::MODE_WAITING;
						position_d  = '0;
						remaining_d = '0;
						total_d     = '0;
					end
				end
			endcase
		end
	end

endmodule

// File: src/fdmx_queue.sv
// Two-entry result queue between the front part and the output side.
// Its head entry drives the output ports directly. Uses fdmx_pkg.
module fdmx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fdmx_pkg::result_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output fdmx_pkg::result_t head
);

	fdmx_pkg::result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/dual_protocol_frame_demux_top.sv
// Dual protocol frame demultiplexer, top level. Uses fdmx_pkg, fdmx_front, fdmx_queue.
// Each accepted word's result is built combinationally and written into the result queue.
// Throughput: one word per cycle while the result queue is not full; the front updates frame state per word.
// The two-entry result queue lets input keep flowing during an output stall until both entries fill.
// Reset (arst_n low, asynchronous) clears frame state, registers to defaults, the queue.
module dual_protocol_frame_demux_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [fdmx_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fdmx_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic [7:0]                        data,
	// Output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        event_res,
	output logic [7:0]                        byte_out,
	output logic [1:0]                        destination,
	output logic [15:0]                       byte_index,
	output logic [7:0]                        channel_out,
	output logic [15:0]                       frame_len,
	output logic                              crc_mismatch,
	output logic                              timed_out
);

	// Every accepted word, byte or tick, produces exactly one result word.
	// The front holds all frame state and updates it only when a word is
	// accepted, so stalls on either side never disturb the running CRC.
	logic              in_accept;
	logic              out_accept;
	logic              queue_full;
	fdmx_pkg::result_t front_result;
	fdmx_pkg::result_t head;

	// Input is held off only while both queue entries wait to be taken.
	assign in_stall   = queue_full;
	assign in_accept  = in_valid && !queue_full;
	assign out_accept = out_valid && !out_stall;

	fdmx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (in_accept),
		.cmd       (cmd),
		.data      (data),
		.result    (front_result)
	);

	// The queue decouples the classifying front from the consumer.
	fdmx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (front_result),
		.pop       (out_accept),
		.full      (queue_full),
		.not_empty (out_valid),
		.head      (head)
	);

	// The head entry is a register, so the output word is stable while stalled.
	assign event_res    = head.event_res;
	assign byte_out     = head.byte_out;
	assign destination  = head.destination;
	assign byte_index   = head.byte_index;
	assign channel_out  = head.channel_out;
	assign frame_len    = head.frame_len;
	assign crc_mismatch = head.crc_mismatch;
	assign timed_out    = head.timed_out;

endmodule

// File: bench/fdmx_checker.sv
// Checker for the dual protocol frame demultiplexer: follows register writes, predicts one
// result word per accepted input word and compares the result words in order.
// Depends on fdmx_pkg for the result type, the codes and the reset values.
`timescale 1ns / 1ps

module fdmx_checker
	import fdmx_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   cmd,
	input  logic [7:0]             data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [2:0]             event_res,
	input  logic [7:0]             byte_out,
	input  logic [1:0]             destination,
	input  logic [15:0]            byte_index,
	input  logic [7:0]             channel_out,
	input  logic [15:0]            frame_len,
	input  logic                   crc_mismatch,
	input  logic                   timed_out,
	output int unsigned            failures,
	output int unsigned            pending
);

	// Register copies.
	logic [23:0] lim_timeout;
	logic [16:0] lim_max;
	logic [16:0] lim_staging;
	logic [7:0]  strm_chan;

	// Frame state.
	mode_t       md;
	logic [16:0] pos;
	logic [15:0] rem;
	logic [16:0] tot_len;
	logic [7:0]  len_lo;
	logic [7:0]  chan_reg;
	logic [15:0] crc_run;
	logic [7:0]  crc_lo;
	logic        crc_lo_seen;
	logic [23:0] quiet_cnt;

	result_t awaited_results[$];
	result_t oldest;

	// Reflected CRC-16-CCITT, one bit at a time.
	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
		return x;
	endfunction

	function automatic void close_frame();
		md = MODE_WAITING;
		pos = '0;
		rem = '0;
		tot_len = '0;
	endfunction

	function automatic result_t frame_demux_result(input logic c, input logic [7:0] b);
		result_t r;
		int unsigned p;
		logic [15:0] field;
		logic [16:0] total;
		logic [16:0] body;
		r = '0;
		if (c != CMD_BYTE) begin
			if (quiet_cnt != IDLE_MAX)
				quiet_cnt = quiet_cnt + 24'd1;
			return r;
		end
		r.byte_out = b;
		// A stale open frame is dropped before the byte is looked at.
		if (md != MODE_WAITING && quiet_cnt > lim_timeout) begin
			close_frame();
			r.timed_out = 1'b1;
		end
		quiet_cnt = '0;
		r.byte_index = pos[15:0];
		p = 32'(pos);
		body = tot_len - LONG_OVERHEAD;
		case (md)
			MODE_WAITING: begin
				r.byte_index = '0;
				if (b >= SHORT_MIN_LEN && b <= SHORT_MAX_LEN) begin
					md = MODE_SHORT;
					pos = 17'd1;
					rem = {8'h00, b} - 16'd1;
					r.destination = DEST_SHORT;
				end else if (b == LONG_SYNC) begin
					md = MODE_LONG;
					pos = 17'd1;
					tot_len = '0;
					crc_run = CRC_SEED;
					crc_lo_seen = 1'b0;
					r.destination = DEST_LONG;
				end
			end
			MODE_SHORT: begin
				r.destination = DEST_SHORT;
				pos = pos + 17'd1;
				rem = rem - 16'd1;
				if (rem == 16'd0) begin
					r.event_res = EV_SHORT_DONE;
					r.frame_len = pos[15:0];
					close_frame();
				end
			end
			MODE_LONG: begin
				if (pos >= lim_staging) begin
					r.event_res = EV_ERROR;
					close_frame();
				end else if (p == 1) begin
					len_lo = b;
					crc_run = crc_fold(crc_run, b);
					pos = 17'd2;
					r.destination = DEST_LONG;
				end else if (p == 2) begin
					field = {b, len_lo};
					total = {1'b0, field} + 17'd1;
					if (field < LONG_MIN_LEN_FIELD || total > lim_max) begin
						r.event_res = EV_ERROR;
						close_frame();
					end else begin
						tot_len = total;
						crc_run = crc_fold(crc_run, b);
						pos = 17'd3;
						r.destination = DEST_LONG;
					end
				end else if (p == 3) begin
					chan_reg = b;
					r.channel_out = b;
					crc_run = crc_fold(crc_run, b);
					if (b == strm_chan) begin
						rem = body[15:0];
						crc_lo_seen = 1'b0;
						md = MODE_STREAM;
						pos = 17'd4;
						r.event_res = EV_STREAM_BEGIN;
						r.destination = DEST_LONG;
					end else if (tot_len > lim_staging) begin
						r.event_res = EV_ERROR;
						close_frame();
					end else begin
						pos = 17'd4;
						r.destination = DEST_LONG;
					end
				end else begin
					r.channel_out = chan_reg;
					r.destination = DEST_LONG;
					if (p + 2 < tot_len) begin
						crc_run = crc_fold(crc_run, b);
						pos = pos + 17'd1;
					end else if (p + 2 == tot_len) begin
						crc_lo = b;
						pos = pos + 17'd1;
					end else begin
						if ({b, crc_lo} == crc_run) begin
							r.event_res = EV_LONG_GOOD;
							r.frame_len = body[15:0];
						end else begin
							r.event_res = EV_ERROR;
							r.crc_mismatch = 1'b1;
						end
						close_frame();
					end
				end
			end
			default: begin
				r.channel_out = chan_reg;
				if (rem != 16'd0) begin
					crc_run = crc_fold(crc_run, b);
					rem = rem - 16'd1;
					pos = pos + 17'd1;
					r.event_res = EV_STREAM_BYTE;
					r.destination = DEST_STREAM;
				end else if (!crc_lo_seen) begin
					crc_lo = b;
					crc_lo_seen = 1'b1;
					pos = pos + 17'd1;
				end else begin
					if ({b, crc_lo} == crc_run) begin
						r.event_res = EV_STREAM_DONE;
						r.frame_len = body[15:0];
					end else begin
						r.event_res = EV_ERROR;
						r.crc_mismatch = 1'b1;
					end
					close_frame();
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_timeout = TIMEOUT_RESET;
			lim_max = MAX_LEN_RESET;
			lim_staging = STAGING_RESET;
			strm_chan = STREAM_RESET;
			close_frame();
			len_lo = '0;
			chan_reg = '0;
			crc_run = CRC_SEED;
			crc_lo = '0;
			crc_lo_seen = 1'b0;
			quiet_cnt = '0;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: lim_timeout = cfg_data[23:0];
					REG_MAX_LEN: lim_max = cfg_data[16:0];
					REG_STAGING: lim_staging = cfg_data[16:0];
					REG_STREAM:  strm_chan = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					failures++;
					$display("%0t: result word with none awaited, event %0d byte %02h",
						$time, event_res, byte_out);
				end else begin
					oldest = awaited_results.pop_front();
					check_field("event_res", oldest.event_res, event_res);
					check_field("byte_out", oldest.byte_out, byte_out);
					check_field("destination", oldest.destination, destination);
					check_field("byte_index", oldest.byte_index, byte_index);
					check_field("channel_out", oldest.channel_out, channel_out);
					check_field("frame_len", oldest.frame_len, frame_len);
					check_field("crc_mismatch", oldest.crc_mismatch, crc_mismatch);
					check_field("timed_out", oldest.timed_out, timed_out);
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(frame_demux_result(cmd, data));
			pending = awaited_results.size();
		end
	end

endmodule

// File: bench/dual_protocol_frame_demux_top_tb.sv
// Top of the frame demultiplexer bench: clock, reset, register setup and stimulus words.
// Depends on fdmx_pkg, dual_protocol_frame_demux_top and the fdmx_checker module.
`timescale 1ns / 1ps

module dual_protocol_frame_demux_top_tb;
	import fdmx_pkg::*;

	// One stimulus word: a received byte or a timer tick.
	typedef struct {
		logic       cmd;
		logic [7:0] data;
	} word_t;

	localparam logic        TICK_CMD    = ~CMD_BYTE;
	localparam int unsigned WHOLE_FRAME = 32'hffff_ffff;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   cmd;
	logic [7:0]             data;
	logic                   out_valid;
	logic                   out_stall;
	logic [2:0]             event_res;
	logic [7:0]             byte_out;
	logic [1:0]             destination;
	logic [15:0]            byte_index;
	logic [7:0]             channel_out;
	logic [15:0]            frame_len;
	logic                   crc_mismatch;
	logic                   timed_out;
	int unsigned            failures;
	int unsigned            pending;

	// Words waiting to be driven, in order.
	word_t tx_words[$];

	// When set, neither side idles: this gives a long stretch at full rate.
	bit quiet;

	// The bench's view of the registers, used only to shape frames so that most of them
	// get through the length and staging checks.
	int unsigned cur_timeout = 32'(TIMEOUT_RESET);
	int unsigned cur_max     = 32'(MAX_LEN_RESET);
	int unsigned cur_staging = 32'(STAGING_RESET);
	logic [7:0]  cur_stream  = STREAM_RESET;

	dual_protocol_frame_demux_top i_dut (.*);

	// The checker watches both channels and the register port and counts mismatches.
	fdmx_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random, about 30 percent of the time unless quiet is set, independent of out_valid.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !quiet && ($urandom_range(0, 99) < 30);
		end
	end

	// Hard stop in case the block hangs; a correct run needs a small fraction of this.
	initial begin
		#(5_000_000);
		$display("simulation failed");
		$finish;
	end

	// The frame CRC that the sender appends, reflected CCITT polynomial.
	function automatic logic [15:0] crc_ccitt_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
		return x;
	endfunction

	task automatic push_word(input logic c, input logic [7:0] d);
		tx_words.push_back('{c, d});
	endtask

	// Ticks carry random data, which the block must ignore.
	task automatic push_ticks(input int unsigned n);
		repeat (n) push_word(TICK_CMD, 8'($urandom));
	endtask

	// A short frame: the length byte, then the rest of the frame. Only the first cut bytes
	// are queued, which leaves a partial frame open when cut is below len. Now and then a
	// tick lands in the middle of the frame.
	task automatic add_short(input logic [7:0] len, input int unsigned cut);
		push_word(CMD_BYTE, len);
		for (int i = 1; i < len && i < cut; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_ticks(1);
			push_word(CMD_BYTE, 8'($urandom));
		end
	endtask

	// A long frame: sync, length field, channel, random payload and the CRC over
	// everything after the sync byte. With corrupt set, one CRC bit is flipped. Only the
	// first cut words are queued, so that error frames stop where the block gives up.
	task automatic add_long(input logic [15:0] field, input logic [7:0] chan,
			input bit corrupt, input int unsigned cut);
		logic [7:0]  head [4];
		logic [15:0] crc;
		logic [7:0]  b;
		int unsigned n;
		int unsigned plen;
		head = '{LONG_SYNC, field[7:0], field[15:8], chan};
		crc = CRC_SEED;
		n = 0;
		plen = (field >= 16'd5) ? 32'(field - 16'd5) : 0;
		for (int k = 0; k < 4 && n < cut; k++) begin
			if (k != 0)
				crc = crc_ccitt_next(crc, head[k]);
			push_word(CMD_BYTE, head[k]);
			n++;
		end
		for (int i = 0; i < plen && n < cut; i++) begin
			b = 8'($urandom);
			crc = crc_ccitt_next(crc, b);
			push_word(CMD_BYTE, b);
			n++;
		end
		if (corrupt)
			crc = crc ^ (16'd1 << $urandom_range(15, 0));
		if (n < cut)
			push_word(CMD_BYTE, crc[7:0]);
		if (n + 1 < cut)
			push_word(CMD_BYTE, crc[15:8]);
	endtask

	// Total length of a frame that passes the current limits. Most frames are tiny so the
	// run stays short; a few reach a couple of hundred bytes.
	function automatic int unsigned pick_total(input bit streamed);
		int unsigned lim;
		int unsigned hi;
		lim = cur_max;
		if (!streamed && cur_staging < lim)
			lim = cur_staging;
		if (lim > 65536)
			lim = 65536;
		if (lim < 6)
			return 6;
		hi = ($urandom_range(0, 99) < 5) ? 260 : 22;
		if (hi > lim)
			hi = lim;
		return $urandom_range(hi, 6);
	endfunction

	// One random sequence. Most are well-formed frames with random content; the rest are
	// broken frames, noise, stale partial frames and bare ticks.
	task automatic add_random_frame();
		int unsigned pick;
		int unsigned tot;
		int unsigned hi;
		logic [15:0] f;
		logic [7:0]  ch;
		logic [7:0]  other;
		bit          streamed;
		pick = $urandom_range(0, 99);
		streamed = 1'($urandom_range(0, 1));
		other = cur_stream + 8'($urandom_range(1, 255));
		ch = streamed ? cur_stream : other;
		if (pick < 28) begin
			f = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(12, 5) : $urandom_range(64, 5));
			add_short(f[7:0], WHOLE_FRAME);
		end else if (pick < 60) begin
			add_long(16'(pick_total(streamed) - 1), ch, 1'b0, WHOLE_FRAME);
		end else if (pick < 68) begin
			// Good framing but a CRC that disagrees.
			add_long(16'(pick_total(streamed) - 1), ch, 1'b1, WHOLE_FRAME);
		end else if (pick < 75) begin
			// Length field below the minimum, or a total above max_frame_len.
			if ($urandom_range(0, 1) || cur_max >= 65536)
				f = 16'($urandom_range(4, 0));
			else if ($urandom_range(0, 4) == 0)
				f = 16'hffff;
			else
				f = 16'($urandom_range((cur_max + 40 > 65535) ? 65535 : cur_max + 40,
					cur_max));
			add_long(f, ch, 1'b0, 3);
		end else if (pick < 81 && cur_staging < 65536 && cur_staging < cur_max) begin
			// A staged frame that fits max_frame_len but not the staging buffer.
			hi = (cur_max > 65536) ? 65536 : cur_max;
			if ($urandom_range(0, 4) == 0)
				tot = hi;
			else
				tot = $urandom_range((hi < cur_staging + 30) ? hi : cur_staging + 30,
					cur_staging + 1);
			add_long(16'(tot - 1), other, 1'b0, 4);
		end else if (pick < 88) begin
			repeat ($urandom_range(3, 1)) push_word(CMD_BYTE, 8'($urandom));
		end else if (pick < 95) begin
			// A partial frame left to go stale. With a small timeout the tick count lands
			// on the limit itself or just past it.
			if ($urandom_range(0, 1)) begin
				f = 16'($urandom_range(64, 5));
				add_short(f[7:0], $urandom_range(f - 1, 1));
			end else begin
				tot = pick_total(streamed);
				add_long(16'(tot - 1), ch, 1'b0, $urandom_range(tot - 1, 1));
			end
			if (cur_timeout <= 40)
				push_ticks(cur_timeout + $urandom_range(2, 0));
			else
				push_ticks($urandom_range(6, 1));
		end else begin
			push_ticks($urandom_range(4, 1));
		end
	endtask

	// Drives every queued word. A word that is raised stays up, unchanged, until the block
	// takes it; between words the sender idles at random unless quiet is set.
	task automatic send_words();
		bit held;
		held = 1'b0;
		while (tx_words.size() != 0) begin
			@(negedge clk);
			if (!held) begin
				if (!quiet && $urandom_range(0, 99) < 30) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					cmd <= tx_words[0].cmd;
					data <= tx_words[0].data;
					held = 1'b1;
				end
			end
			@(posedge clk);
			if (held && !in_stall) begin
				void'(tx_words.pop_front());
				held = 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Waits until every awaited result word has come out, then lets the output queue
	// settle. The bound keeps a stuck block from hanging here; the final verdict still
	// sees the words left over.
	task automatic wait_drained();
		int unsigned n;
		n = 0;
		@(negedge clk);
		while (pending != 0 && n < 20000) begin
			@(negedge clk);
			n++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic configure(input logic [23:0] t, input logic [23:0] m, input logic [23:0] s,
			input logic [23:0] c);
		write_reg(REG_TIMEOUT, t);
		write_reg(REG_MAX_LEN, m);
		write_reg(REG_STAGING, s);
		write_reg(REG_STREAM, c);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_timeout = 32'(t);
		cur_max = 32'(m[16:0]);
		cur_staging = 32'(s[16:0]);
		cur_stream = c[7:0];
	endtask

	// One phase: registers are only changed once the block has nothing in flight.
	task automatic run_phase(input logic [23:0] t, input logic [23:0] m, input logic [23:0] s,
			input logic [23:0] c, input int unsigned target, input bit q);
		wait_drained();
		configure(t, m, s, c);
		quiet = q;
		while (tx_words.size() < target)
			add_random_frame();
		send_words();
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_BYTE;
		data = '0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset register values: a tick, bytes that start nothing,
		// the shortest short frame, a length field below the minimum, a length above
		// max_frame_len, an empty streamed frame and a staged frame with a bad CRC.
		push_word(TICK_CMD, 8'hff);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_BYTE, 8'hff);
		add_short(8'd5, WHOLE_FRAME);
		add_long(16'd4, 8'h00, 1'b0, 3);
		add_long(16'hffff, 8'h00, 1'b0, 3);
		add_long(16'd5, cur_stream, 1'b0, WHOLE_FRAME);
		add_long(16'd6, cur_stream + 8'd1, 1'b1, WHOLE_FRAME);
		send_words();

		// Random phases. The first keeps the reset values. Then: a small timeout; the timeout
		// and length registers at their low extremes; the same at their high extremes with no
		// idling on either side; a staging buffer too small for any long frame; a few random
		// settings; and full-width writes that the block must mask.
		while (tx_words.size() < 200)
			add_random_frame();
		send_words();
		run_phase(24'd3, 24'd200, 24'd100, 24'($urandom_range(255, 0)), 200, 1'b0);
		run_phase(24'd0, 24'd6, 24'd6, 24'd255, 150, 1'b0);
		run_phase(24'hffffff, 24'd65536, 24'd65536, 24'd0, 200, 1'b1);
		run_phase(24'd5, 24'd65536, 24'd3, 24'($urandom_range(255, 0)), 150, 1'b0);
		repeat (3)
			run_phase(24'($urandom_range(20, 0)), 24'($urandom_range(600, 6)),
				24'($urandom_range(600, 0)), 24'($urandom_range(255, 0)), 150, 1'b0);
		run_phase(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 150, 1'b0);

		wait_drained();
		repeat (8) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
